FILE: hdl/sbrc_pkg.sv
`timescale 1ns / 1ps

package sbrc_pkg;

  localparam int MAX_PINS = 64;
  localparam int NET_CAP  = MAX_PINS / 2;

  localparam int PIN_W   = 7;
  localparam int DEPTH_W = $clog2(MAX_PINS + 1);
  localparam int ADDR_W  = $clog2(MAX_PINS);
  localparam int NET_AW  = $clog2(NET_CAP);
  localparam int NCNT_W  = $clog2(NET_CAP + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic [PIN_W-1:0] pin_a;
    logic [PIN_W-1:0] pin_b;
  } net_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_STEP  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_TOPLD = 5'b10000
  } state_e;

  function automatic logic net_pairs(net_t net, logic [PIN_W-1:0] top,
                                     logic [PIN_W-1:0] cur);
    return ((net.pin_a == top) && (net.pin_b == cur)) ||
           ((net.pin_a == cur) && (net.pin_b == top));
  endfunction

endpackage

FILE: hdl/switch_box_routability_check_core.sv
`timescale 1ns / 1ps

// Switch-box routability checker. A word with op set to load appends one net,
// a pair of pin numbers, to a table of up to MAX_PINS/2 nets; loads past a
// full table are dropped. A word with op set to check walks the pins 1 to
// pin_count (capped at MAX_PINS) with a pin stack and returns one word whose
// routable bit is set when the stack ends empty. The check is run by a small
// sequencer around a single net comparator that scans the table one entry
// per cycle. A pin that meets an empty stack is pushed directly; otherwise the
// table is scanned in full and the pin is pushed if no net pairs it with the
// stack top, or the scan stops at the hit and the top is popped, with the new
// top re-read from the stack memory when the stack is not empty after the
// pop. The input stalls for the whole check. The result sits in an output
// register, and a finished check waits only if an earlier result has not
// yet been taken.
module switch_box_routability_check_core
  import sbrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PIN_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [PIN_W-1:0] pin_a_i,
  input  logic [PIN_W-1:0] pin_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             routable_o
);

  state_e              state_q, state_d;
  logic [PIN_W-1:0]    pin_count_q;
  logic [NCNT_W-1:0]   nets_loaded_q, nets_loaded_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [PIN_W-1:0]    pin_q, pin_d;
  logic [PIN_W-1:0]    last_q, last_d;
  logic [PIN_W-1:0]    top_q, top_d;
  logic [NCNT_W-1:0]   idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                out_valid_q, out_valid_d;
  logic                routable_q, routable_d;

  net_t                net_mem [NET_CAP];
  net_t                tbl_rd_q;
  logic                tbl_we;
  logic [PIN_W-1:0]    stk_mem [MAX_PINS];
  logic [PIN_W-1:0]    stk_rd_q;
  logic                stk_we;
  logic [ADDR_W-1:0]   stk_rd_addr;

  logic                in_acc;
  logic                out_free;
  logic                hit;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign routable_o  = routable_q;
  assign stk_rd_addr = ADDR_W'(depth_q - DEPTH_W'(1));
  assign hit         = cmp_vld_q && net_pairs(tbl_rd_q, top_q, pin_q);

  always_comb begin
    state_d       = state_q;
    nets_loaded_d = nets_loaded_q;
    depth_d       = depth_q;
    pin_d         = pin_q;
    last_d        = last_q;
    top_d         = top_q;
    idx_d         = idx_q;
    cmp_vld_d     = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    routable_d    = routable_q;
    tbl_we        = 1'b0;
    stk_we        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_LOAD) begin
            if (nets_loaded_q < NCNT_W'(NET_CAP)) begin
              tbl_we        = 1'b1;
              nets_loaded_d = nets_loaded_q + NCNT_W'(1);
            end
          end else begin
            depth_d = '0;
            pin_d   = PIN_W'(1);
            last_d  = (pin_count_q > PIN_W'(MAX_PINS)) ? PIN_W'(MAX_PINS) : pin_count_q;
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (pin_q > last_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            routable_d  = (depth_q == '0);
            state_d     = ST_IDLE;
          end
        end else if (depth_q == '0) begin
          stk_we  = 1'b1;
          depth_d = DEPTH_W'(1);
          top_d   = pin_q;
          pin_d   = pin_q + PIN_W'(1);
        end else begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < nets_loaded_q) begin
          idx_d     = idx_q + NCNT_W'(1);
          cmp_vld_d = 1'b1;
        end
        if (hit) begin
          depth_d   = depth_q - DEPTH_W'(1);
          pin_d     = pin_q + PIN_W'(1);
          cmp_vld_d = 1'b0;
          state_d   = (depth_q == DEPTH_W'(1)) ? ST_STEP : ST_FETCH;
        end else if (!cmp_vld_q && (idx_q >= nets_loaded_q)) begin
          if (depth_q < DEPTH_W'(MAX_PINS)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + DEPTH_W'(1);
            top_d   = pin_q;
          end
          pin_d   = pin_q + PIN_W'(1);
          state_d = ST_STEP;
        end
      end
      ST_FETCH: begin
        state_d = ST_TOPLD;
      end
      ST_TOPLD: begin
        top_d   = stk_rd_q;
        state_d = ST_STEP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pin_count_q   <= '0;
      nets_loaded_q <= '0;
      depth_q       <= '0;
      pin_q         <= '0;
      last_q        <= '0;
      idx_q         <= '0;
      cmp_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      nets_loaded_q <= nets_loaded_d;
      depth_q       <= depth_d;
      pin_q         <= pin_d;
      last_q        <= last_d;
      idx_q         <= idx_d;
      cmp_vld_q     <= cmp_vld_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        pin_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    routable_q <= routable_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      net_mem[nets_loaded_q[NET_AW-1:0]] <= '{pin_a: pin_a_i, pin_b: pin_b_i};
    end
    tbl_rd_q <= net_mem[idx_q[NET_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[depth_q[ADDR_W-1:0]] <= pin_q;
    end
    stk_rd_q <= stk_mem[stk_rd_addr];
  end

endmodule

FILE: hdl/sbrc_checker.sv
`timescale 1ns / 1ps

module sbrc_checker
  import sbrc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             op_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             routable_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(routable_o))
    else $error("result word dropped or changed while stalled");

  // A load never produces a result word.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load produced a result word");

  // A check keeps the input stalled while it runs.
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == OP_CHECK) |=> in_stall_o)
    else $error("input not stalled after a check was accepted");

  // A new result only appears at the end of a running check.
  a_out_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a running check");

endmodule

bind switch_box_routability_check_core sbrc_checker u_sbrc_checker (.*);
